// ===== rtl/ssd_pkg.sv =====
// Shared constants and result type for the syslog stream deframer.
// No dependencies; imported by the deframer top level.
package ssd_pkg;

  localparam int unsigned LengthDigitsDefault = 7;
  localparam int unsigned ResultDepth         = 4;

  localparam logic [15:0] KeptLenReset  = 16'd2048;
  localparam logic [23:0] FrameLenReset = 24'd1048576;
  localparam logic [23:0] AccMax        = 24'hFFFFFF;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharOne   = 8'h31;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;

  localparam logic [3:0] RegMaxKeptLen  = 4'd0;
  localparam logic [3:0] RegMaxFrameLen = 4'd1;

  typedef enum logic [1:0] {
    KindPayload  = 2'd0,
    KindFrameEnd = 2'd1,
    KindError    = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload;
    logic [15:0] frame_length;
    logic        last;
  } result_t;

endpackage

// ===== rtl/syslog_stream_deframer_unit.sv =====
// Syslog stream deframer: octet-counting and LF-delimited framing of a byte stream.
// Depends on ssd_pkg for constants and the result record type.
// Each result is written into the result queue when its byte is accepted.
// Throughput: one byte per cycle while at least two of four result queue entries are free;
// the queue drains one result per cycle while m_axis_tready_i is high.
// Reset clears framing state and queue, max_kept_len 2048, max_frame_len 1048576.
module syslog_stream_deframer_unit #(
  parameter int unsigned LengthDigits = ssd_pkg::LengthDigitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] payload, [23:8] frame_length
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import ssd_pkg::*;

  localparam int unsigned DigitW = $clog2(LengthDigits + 1);
  localparam int unsigned PtrW   = $clog2(ResultDepth);
  localparam int unsigned CntW   = $clog2(ResultDepth + 1);

  localparam logic [1:0] ModeUnknown = 2'd0;
  localparam logic [1:0] ModeOctet   = 2'd1;
  localparam logic [1:0] ModeLf      = 2'd2;

  logic [15:0]       max_kept_q;
  logic [23:0]       max_frame_q;
  logic [1:0]        mode_q, mode_d;
  logic              in_payload_q, in_payload_d;
  logic              err_q, err_d;
  logic [23:0]       acc_q, acc_d;
  logic [DigitW-1:0] digits_q, digits_d;
  logic [23:0]       remain_q, remain_d;
  logic [15:0]       kept_q, kept_d;
  logic              stopped_q, stopped_d;
  logic              cr_q, cr_d;

  result_t           queue_q [ResultDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  logic        accept, pop;
  logic [7:0]  c;
  logic        is_digit, first_octet;
  logic [27:0] acc_ext;
  logic [23:0] remain_dec;
  logic [15:0] kept_inc, lf_len;
  logic        a_vld, b_vld;
  result_t     res_a, res_b, res0, res1;
  logic [1:0]  n_res;

  assign c           = s_axis_tdata_i;
  assign accept      = s_axis_tvalid_i && s_axis_tready_o;
  assign pop         = m_axis_tvalid_o && m_axis_tready_i;
  assign cfg_ready_o = 1'b1;
  assign is_digit    = (c >= CharZero) && (c <= CharNine);
  assign first_octet = (c >= CharOne) && (c <= CharNine);
  assign acc_ext     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {20'd0, c - CharZero};
  assign remain_dec  = (remain_q != 24'd0) ? remain_q - 24'd1 : 24'd0;
  assign kept_inc    = kept_q + 16'd1;
  assign lf_len      = (cr_q && kept_q != 16'd0) ? kept_q - 16'd1 : kept_q;

  always_comb begin
    mode_d       = mode_q;
    in_payload_d = in_payload_q;
    err_d        = err_q;
    acc_d        = acc_q;
    digits_d     = digits_q;
    remain_d     = remain_q;
    kept_d       = kept_q;
    stopped_d    = stopped_q;
    cr_d         = cr_q;
    a_vld        = 1'b0;
    b_vld        = 1'b0;
    res_a        = '{kind: KindPayload, payload: c, frame_length: 16'd0, last: 1'b0};
    res_b        = '{kind: KindFrameEnd, payload: 8'd0, frame_length: 16'd0, last: 1'b0};
    if (!err_q) begin
      if (mode_q == ModeUnknown) begin
        mode_d = first_octet ? ModeOctet : ModeLf;
      end
      if (mode_d == ModeOctet) begin
        if (!in_payload_q) begin
          if (is_digit) begin
            if (digits_q >= DigitW'(LengthDigits)) begin
              err_d = 1'b1;
            end else begin
              acc_d    = (acc_ext > {4'd0, AccMax}) ? AccMax : acc_ext[23:0];
              digits_d = digits_q + DigitW'(1);
            end
          end else if (c == CharSpace) begin
            acc_d    = 24'd0;
            digits_d = '0;
            if (digits_q == '0 || acc_q == 24'd0 || acc_q > max_frame_q) begin
              err_d = 1'b1;
            end else begin
              remain_d     = acc_q;
              kept_d       = 16'd0;
              in_payload_d = 1'b1;
            end
          end else begin
            err_d = 1'b1;
          end
          if (err_d) begin
            b_vld = 1'b1;
            res_b.kind = KindError;
          end
        end else begin
          if (kept_q < max_kept_q) begin
            a_vld  = 1'b1;
            kept_d = kept_inc;
          end
          remain_d = remain_dec;
          if (remain_dec == 24'd0) begin
            b_vld              = 1'b1;
            res_b.frame_length = kept_d;
            in_payload_d       = 1'b0;
            kept_d             = 16'd0;
          end
        end
      end else begin
        if (c == CharLf) begin
          cr_d               = 1'b0;
          b_vld              = (lf_len != 16'd0);
          res_b.frame_length = lf_len;
          kept_d             = 16'd0;
          stopped_d          = 1'b0;
        end else if (!stopped_q) begin
          if (kept_q < max_kept_q) begin
            a_vld         = cr_q;
            res_a.payload = CharCr;
            cr_d          = (c == CharCr);
            b_vld         = (c != CharCr);
            res_b.kind    = KindPayload;
            res_b.payload = c;
            kept_d        = kept_inc;
          end else begin
            stopped_d = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    n_res     = {1'b0, a_vld} + {1'b0, b_vld};
    res0      = a_vld ? res_a : res_b;
    res1      = res_b;
    res0.last = (n_res == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_kept_q  <= KeptLenReset;
      max_frame_q <= FrameLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegMaxKeptLen:  max_kept_q  <= cfg_data_i[15:0];
        RegMaxFrameLen: max_frame_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeUnknown;
      in_payload_q <= 1'b0;
      err_q        <= 1'b0;
      acc_q        <= 24'd0;
      digits_q     <= '0;
      remain_q     <= 24'd0;
      kept_q       <= 16'd0;
      stopped_q    <= 1'b0;
      cr_q         <= 1'b0;
    end else if (accept) begin
      mode_q       <= mode_d;
      in_payload_q <= in_payload_d;
      err_q        <= err_d;
      acc_q        <= acc_d;
      digits_q     <= digits_d;
      remain_q     <= remain_d;
      kept_q       <= kept_d;
      stopped_q    <= stopped_d;
      cr_q         <= cr_d;
    end
  end

  assign s_axis_tready_o = (count_q <= CntW'(ResultDepth - 2));
  assign m_axis_tvalid_o = (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (accept && n_res != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (accept && n_res == 2'd2) begin
      queue_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (accept) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(n_res);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + (accept ? CntW'(n_res) : CntW'(0)) - (pop ? CntW'(1) : CntW'(0));
    end
  end

  assign m_axis_tuser_o = queue_q[rd_ptr_q].kind;
  assign m_axis_tdata_o = {queue_q[rd_ptr_q].frame_length, queue_q[rd_ptr_q].payload};
  assign m_axis_tlast_o = queue_q[rd_ptr_q].last;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ResultDepth))
    else $error("result queue overfilled");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q)
    else $error("protocol error cleared without reset");

  a_silent_after_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && err_q) |-> (n_res == 2'd0))
    else $error("result produced after protocol error");

  a_payload_octet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (mode_q == ModeOctet))
    else $error("payload state outside octet counting");

endmodule

// ===== dv/tb_syslog_stream_deframer_unit.sv =====
// Self-checking testbench for syslog_stream_deframer_unit: random byte streams
// in one framing mode per run, checked against a built-in frame predictor.
// Depends on ssd_pkg and the deframer RTL only.
`timescale 1ns / 100ps

module tb_syslog_stream_deframer_unit;
  import ssd_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomItems   = 850;
  localparam int unsigned QuietAfter    = 700;
  localparam int unsigned SettleCycles  = 3;
  localparam int unsigned DrainCycles   = 10;

  typedef enum int {
    FlawLongLength,
    FlawBareSpace,
    FlawZeroLength,
    FlawOverLimit,
    FlawStrayByte
  } flaw_e;

  class deframe_scoreboard;
    typedef enum logic [1:0] {
      FramingUnknown = 2'd0,
      FramingOctet   = 2'd1,
      FramingLine    = 2'd2
    } framing_e;

    int unsigned kept_limit;
    int unsigned frame_limit;
    framing_e    framing;
    bit          in_payload;
    bit          halted;
    bit          copy_stopped;
    bit          cr_held;
    int unsigned length_acc;
    int unsigned digits_seen;
    int unsigned remaining;
    int unsigned kept;
    result_t     results_due[$];
    result_t     step_out[2];
    int          step_n;
    int          mismatches;

    function new();
      kept_limit   = KeptLenReset;
      frame_limit  = FrameLenReset;
      framing      = FramingUnknown;
      in_payload   = 1'b0;
      halted       = 1'b0;
      copy_stopped = 1'b0;
      cr_held      = 1'b0;
      length_acc   = 0;
      digits_seen  = 0;
      remaining    = 0;
      kept         = 0;
      step_n       = 0;
      mismatches   = 0;
    endfunction

    function void set_register(logic [3:0] index, logic [23:0] data);
      if (index == RegMaxKeptLen) kept_limit = data[15:0];
      else if (index == RegMaxFrameLen) frame_limit = data;
    endfunction

    function void add_result(kind_e k, logic [7:0] p, logic [15:0] f);
      result_t r;
      r.kind         = k;
      r.payload      = p;
      r.frame_length = f;
      r.last         = 1'b0;
      step_out[step_n] = r;
      step_n++;
    endfunction

    function void flag_error();
      halted = 1'b1;
      add_result(KindError, 8'd0, 16'd0);
    endfunction

    function void count_byte(logic [7:0] c);
      int unsigned wide;
      int unsigned len;
      if (!in_payload) begin
        if (c >= CharZero && c <= CharNine) begin
          if (digits_seen >= LengthDigitsDefault) begin
            flag_error();
            return;
          end
          wide = length_acc * 10 + (c - CharZero);
          length_acc = (wide > AccMax) ? AccMax : wide;
          digits_seen++;
          return;
        end
        if (c == CharSpace) begin
          len = length_acc;
          if (digits_seen == 0) begin
            flag_error();
            return;
          end
          length_acc  = 0;
          digits_seen = 0;
          if (len == 0 || len > frame_limit) begin
            flag_error();
            return;
          end
          remaining  = len;
          kept       = 0;
          in_payload = 1'b1;
          return;
        end
        flag_error();
        return;
      end
      if (kept < kept_limit) begin
        add_result(KindPayload, c, 16'd0);
        kept++;
      end
      if (remaining > 0) remaining--;
      if (remaining == 0) begin
        add_result(KindFrameEnd, 8'd0, kept[15:0]);
        in_payload = 1'b0;
        kept       = 0;
      end
    endfunction

    function void line_byte(logic [7:0] c);
      if (c == CharLf) begin
        if (cr_held) begin
          cr_held = 1'b0;
          if (kept > 0) kept--;
        end
        if (kept > 0) add_result(KindFrameEnd, 8'd0, kept[15:0]);
        kept         = 0;
        copy_stopped = 1'b0;
        return;
      end
      if (copy_stopped) return;
      if (kept < kept_limit) begin
        if (cr_held) begin
          add_result(KindPayload, CharCr, 16'd0);
          cr_held = 1'b0;
        end
        if (c == CharCr) cr_held = 1'b1;
        else add_result(KindPayload, c, 16'd0);
        kept++;
      end else begin
        copy_stopped = 1'b1;
      end
    endfunction

    function void absorb_byte(logic [7:0] c);
      step_n = 0;
      if (halted) return;
      if (framing == FramingUnknown)
        framing = (c >= CharOne && c <= CharNine) ? FramingOctet : FramingLine;
      if (framing == FramingOctet) count_byte(c);
      else line_byte(c);
      for (int i = 0; i < step_n; i++) begin
        if (i == step_n - 1) step_out[i].last = 1'b1;
        results_due.push_back(step_out[i]);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, got kind %0d payload 0x%02h length %0d last %0b",
                 $time, got.kind, got.payload, got.frame_length, got.last);
        return;
      end
      want = results_due.pop_front();
      if (got.kind !== want.kind || got.payload !== want.payload ||
          got.frame_length !== want.frame_length || got.last !== want.last) begin
        mismatches++;
        $display("%0t: result mismatch: expected kind %0d payload 0x%02h length %0d last %0b",
                 $time, want.kind, want.payload, want.frame_length, want.last);
        $display("%0t:                  got kind %0d payload 0x%02h length %0d last %0b",
                 $time, got.kind, got.payload, got.frame_length, got.last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [23:0] cfg_data;

  deframe_scoreboard sb;
  logic [7:0]        outgoing[$];
  int unsigned       random_sent = 0;
  bit                counting = 1'b0;
  bit                quiet = 1'b0;
  int unsigned       send_gap_odds = 0;
  int unsigned       take_gap_odds = 0;
  bit                octet_run;

  syslog_stream_deframer_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    result_t got;
    if (s_axis_tvalid && s_axis_tready) sb.absorb_byte(s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) begin
      got.kind         = kind_e'(m_axis_tuser);
      got.payload      = m_axis_tdata[7:0];
      got.frame_length = m_axis_tdata[23:8];
      got.last         = m_axis_tlast;
      sb.check_result(got);
    end
  end

  initial begin : result_sink
    forever begin
      @(negedge clk_i);
      if (take_gap_odds != 0 && $urandom_range(1, take_gap_odds) == 1) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("syslog_stream_deframer_unit regression: fail");
    $finish;
  end

  function automatic int unsigned least(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic void push_text(string t);
    for (int i = 0; i < t.len(); i++) outgoing.push_back(t[i]);
  endfunction

  function automatic void push_digits(int unsigned value, int unsigned width);
    string s;
    s = $sformatf("%0d", value);
    if (width > s.len()) repeat (width - s.len()) outgoing.push_back(CharZero);
    push_text(s);
  endfunction

  function automatic void push_counted_frame();
    int unsigned cap;
    int unsigned len;
    int unsigned width;
    cap = sb.frame_limit;
    case ($urandom_range(0, 9))
      7, 8:    len = $urandom_range(1, least(cap, 40));
      9:       len = $urandom_range(1, least(cap, 200));
      default: len = $urandom_range(1, least(cap, 10));
    endcase
    width = ($urandom_range(0, 3) == 0) ? $urandom_range(1, LengthDigitsDefault) : 0;
    push_digits(len, width);
    outgoing.push_back(CharSpace);
    repeat (len) outgoing.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void push_line();
    int unsigned len;
    logic [7:0]  b;
    case ($urandom_range(0, 7))
      0:       len = 0;
      1:       len = $urandom_range(1, least(sb.kept_limit + 4, 60));
      default: len = $urandom_range(1, 12);
    endcase
    repeat (len) begin
      b = ($urandom_range(0, 9) == 0) ? CharCr : 8'($urandom_range(0, 255));
      if (b == CharLf && $urandom_range(0, 3) != 0) b = 8'h41;
      outgoing.push_back(b);
    end
    case ($urandom_range(0, 5))
      0: begin
        outgoing.push_back(CharCr);
        outgoing.push_back(CharLf);
      end
      1: begin
        outgoing.push_back(CharCr);
        outgoing.push_back(CharCr);
        outgoing.push_back(CharLf);
      end
      2: begin
        outgoing.push_back(CharLf);
        outgoing.push_back(CharLf);
      end
      3: ;
      default: outgoing.push_back(CharLf);
    endcase
  endfunction

  function automatic logic [23:0] random_kept_word();
    logic [15:0] kept;
    case ($urandom_range(0, 5))
      0:       kept = 16'd0;
      1:       kept = 16'($urandom_range(1, 4));
      2:       kept = 16'($urandom_range(1, 16));
      3:       kept = 16'hFFFF;
      4:       kept = 16'($urandom_range(0, 65535));
      default: kept = KeptLenReset;
    endcase
    return {8'($urandom_range(0, 255)), kept};
  endfunction

  function automatic logic [23:0] random_frame_word();
    case ($urandom_range(0, 4))
      0:       return 24'd1;
      1:       return 24'hFFFFFF;
      2:       return 24'd9999999;
      3:       return 24'($urandom_range(1, 64));
      default: return 24'($urandom_range(1, 24'hFFFFFF));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    if (counting) random_sent++;
    @(negedge clk_i);
  endtask

  // Hold the stream until every predicted result is out, then let the pipe settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.results_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [3:0] index, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    sb.set_register(index, data);
    @(negedge clk_i);
  endtask

  task automatic configure(input bit set_kept, input logic [23:0] kept_word,
                           input bit set_frame, input logic [23:0] frame_word);
    wait_idle();
    if (set_kept) write_reg(RegMaxKeptLen, kept_word);
    if (set_frame) write_reg(RegMaxFrameLen, frame_word);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input bit may_split);
    int split;
    split = -1;
    if (may_split && outgoing.size() > 1 && $urandom_range(0, 2) == 0)
      split = $urandom_range(1, outgoing.size() - 1);
    for (int i = 0; outgoing.size() > 0; i++) begin
      if (i == split) configure(1'b1, random_kept_word(), 1'b0, 24'd0);
      send_byte(outgoing.pop_front());
    end
  endtask

  task automatic pick_pace();
    int unsigned odds[4] = '{0, 2, 6, 20};
    send_gap_odds = quiet ? 0 : odds[$urandom_range(0, 3)];
    take_gap_odds = quiet ? 0 : odds[$urandom_range(0, 3)];
  endtask

  task automatic break_header();
    flaw_e       flaw;
    logic [7:0]  b;
    logic [23:0] limit;
    flaw = flaw_e'($urandom_range(FlawLongLength, FlawStrayByte));
    case (flaw)
      FlawLongLength: repeat (LengthDigitsDefault + 1) outgoing.push_back(CharOne);
      FlawBareSpace:  outgoing.push_back(CharSpace);
      FlawZeroLength: push_text("000 ");
      FlawOverLimit: begin
        limit = 24'($urandom_range(0, 100));
        configure(1'b0, 24'd0, 1'b1, limit);
        push_digits(limit + 1, 0);
        outgoing.push_back(CharSpace);
      end
      default: begin
        do b = 8'($urandom_range(0, 255));
        while ((b >= CharZero && b <= CharNine) || b == CharSpace);
        outgoing.push_back(b);
      end
    endcase
    repeat (16) outgoing.push_back(8'($urandom_range(0, 255)));
    run_phase(1'b0);
  endtask

  initial begin : stimulus
    int unsigned phase;
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    cfg_valid     = 1'b0;
    cfg_index     = RegMaxKeptLen;
    cfg_data      = 24'd0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    octet_run     = $urandom_range(0, 1);
    send_gap_odds = 4;
    take_gap_odds = 4;
    if (octet_run) begin
      push_text("1 ");
      outgoing.push_back(8'hFF);
      push_text("0000003 ");
      outgoing.push_back(8'h00);
      outgoing.push_back(8'h80);
      outgoing.push_back(8'h7F);
      run_phase(1'b0);
      configure(1'b1, 24'd0, 1'b0, 24'd0);
      push_text("2 ab");
      run_phase(1'b0);
      configure(1'b1, 24'd2, 1'b0, 24'd0);
      push_text("5 vwxyz");
      run_phase(1'b0);
    end else begin
      outgoing.push_back(CharLf);
      outgoing.push_back(CharCr);
      outgoing.push_back(CharLf);
      outgoing.push_back(8'hFF);
      outgoing.push_back(8'h00);
      outgoing.push_back(CharCr);
      push_text("b");
      outgoing.push_back(CharCr);
      outgoing.push_back(CharLf);
      run_phase(1'b0);
      configure(1'b1, 24'd2, 1'b0, 24'd0);
      push_text("a");
      outgoing.push_back(CharCr);
      push_text("X");
      outgoing.push_back(CharLf);
      push_text("abc");
      outgoing.push_back(CharLf);
      run_phase(1'b0);
    end

    counting = 1'b1;
    phase    = 0;
    while (random_sent < RandomItems) begin
      quiet = (random_sent > QuietAfter);
      pick_pace();
      case (phase)
        0:       configure(1'b1, 24'd1, 1'b1, 24'hFFFFFF);
        1:       configure(1'b1, 24'd0, 1'b1, 24'd1);
        2:       configure(1'b1, 24'hFFFFFF, 1'b1, 24'd9999999);
        default: configure($urandom_range(0, 3) != 0, random_kept_word(),
                           $urandom_range(0, 1), random_frame_word());
      endcase
      if (octet_run) repeat ($urandom_range(2, 6)) push_counted_frame();
      else repeat ($urandom_range(2, 8)) push_line();
      run_phase(1'b1);
      phase++;
    end
    counting = 1'b0;

    if (octet_run) break_header();
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.results_due.size() == 0)
      $display("syslog_stream_deframer_unit regression: pass");
    else
      $display("syslog_stream_deframer_unit regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ssd_pkg.sv
rtl/syslog_stream_deframer_unit.sv
dv/tb_syslog_stream_deframer_unit.sv
